FILE: design/ksh_pkg.sv
package ksh_pkg;
  localparam int Lanes = 25;
  localparam int StateBytes = 200;
  localparam int Rounds = 24;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [7:0] LfsrPoly = 8'h71;

  typedef logic [63:0] lane_t;
  typedef lane_t [Lanes-1:0] state_t;

  typedef enum logic [1:0] {
    CFG_RATE   = 2'd0,
    CFG_SUFFIX = 2'd1,
    CFG_OUTLEN = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic       clear;
    logic       xor_en;
    logic [7:0] xor_pos;
    logic [7:0] xor_val;
    logic       perm_start;
  } dp_cmd_t;

  typedef struct packed {
    logic perm_busy;
  } dp_stat_t;

  function automatic lane_t rotl(input lane_t v, input int r);
    lane_t res;
    res = (r % 64 == 0) ? v : ((v << (r % 64)) | (v >> (64 - (r % 64))));
    return res;
  endfunction

  function automatic int rho_off(input int idx);
    int px, py, ny, res;
    px = 1; py = 0; res = 0;
    for (int t = 0; t < 24; t++) begin
      ny = (2 * px + 3 * py) % 5;
      px = py;
      py = ny;
      if (px + 5 * py == idx) res = ((t + 1) * (t + 2) / 2) % 64;
    end
    return res;
  endfunction

  function automatic int pi_src(input int idx);
    int px, py, ny, prev, res;
    px = 1; py = 0; prev = 1; res = 0;
    for (int t = 0; t < 24; t++) begin
      ny = (2 * px + 3 * py) % 5;
      px = py;
      py = ny;
      if (px + 5 * py == idx) res = prev;
      prev = px + 5 * py;
    end
    return res;
  endfunction

  // One round including iota; rc is the round constant lane.
  function automatic state_t keccak_round(input state_t s, input lane_t rc);
    lane_t [4:0] c;
    lane_t [4:0] d;
    state_t a;
    state_t b;
    state_t o;
    for (int x = 0; x < 5; x++) c[x] = s[x] ^ s[x+5] ^ s[x+10] ^ s[x+15] ^ s[x+20];
    for (int x = 0; x < 5; x++) d[x] = c[(x+4)%5] ^ rotl(c[(x+1)%5], 1);
    for (int i = 0; i < 25; i++) a[i] = s[i] ^ d[i%5];
    b[0] = a[0];
    for (int i = 1; i < 25; i++) b[i] = rotl(a[pi_src(i)], rho_off(i));
    for (int y = 0; y < 5; y++)
      for (int x = 0; x < 5; x++)
        o[x+5*y] = b[x+5*y] ^ (~b[(x+1)%5+5*y] & b[(x+2)%5+5*y]);
    o[0] = o[0] ^ rc;
    return o;
  endfunction
endpackage

FILE: design/ksh_stream_if.sv
interface ksh_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/ksh_datapath.sv
module ksh_datapath (
  input  logic             clk,
  input  logic             rst,
  input  ksh_pkg::dp_cmd_t cmd,
  output ksh_pkg::dp_stat_t stat,
  output logic [7:0]       rd_byte,
  input  logic [7:0]       rd_pos
);
  ksh_pkg::state_t st;
  ksh_pkg::state_t st_next;
  logic [4:0] round;
  logic       busy;
  logic [7:0] lfsr;
  logic [7:0] lfsr_next;
  ksh_pkg::lane_t rc;

  // Seven LFSR steps give one round constant.
  always_comb begin
    logic [7:0] l;
    l = lfsr;
    rc = '0;
    for (int j = 0; j < 7; j++) begin
      if (l[0]) rc[(1 << j) - 1] = 1'b1;
      l = l[7] ? ((l << 1) ^ ksh_pkg::LfsrPoly) : (l << 1);
    end
    lfsr_next = l;
  end

  always_comb begin
    st_next = st;
    if (busy) begin
      st_next = ksh_pkg::keccak_round(st, rc);
    end else if (cmd.clear) begin
      st_next = '0;
    end else if (cmd.xor_en) begin
      st_next[cmd.xor_pos[7:3]] = st[cmd.xor_pos[7:3]] ^
        (ksh_pkg::lane_t'(cmd.xor_val) << {cmd.xor_pos[2:0], 3'b000});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      busy <= 1'b0;
      round <= '0;
      lfsr <= 8'h01;
    end else begin
      st <= st_next;
      if (busy) begin
        lfsr <= lfsr_next;
        if (round == 5'(ksh_pkg::Rounds - 1)) busy <= 1'b0;
        round <= round + 5'd1;
      end else if (cmd.perm_start) begin
        busy <= 1'b1;
        round <= '0;
        lfsr <= 8'h01;
      end
    end
  end

  assign stat.perm_busy = busy;
  assign rd_byte = 8'(st[rd_pos[7:3]] >> {rd_pos[2:0], 3'b000});

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> round < 5'(ksh_pkg::Rounds)) else $error("round out of range");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> round == 5'd0) else $error("bad round start");
  a_ends: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(round) == 5'(ksh_pkg::Rounds - 1)) else $error("bad round end");
endmodule

FILE: design/ksh_ctrl.sv
module ksh_ctrl #(
  parameter int MaxOut = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        message_byte,
  input  logic              has_byte,
  input  logic              end_of_message,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        digest_byte,
  output logic              last_byte,
  input  logic [7:0]        rate_bytes,
  input  logic [7:0]        domain_suffix,
  input  logic [6:0]        output_bytes,
  output ksh_pkg::dp_cmd_t  cmd,
  input  ksh_pkg::dp_stat_t stat,
  input  logic [7:0]        rd_byte,
  output logic [7:0]        rd_pos
);
  typedef enum logic [3:0] {
    S_IDLE, S_ABS, S_ABS_W, S_EOM, S_SUF, S_SUF_W, S_PAD, S_PAD_W,
    S_SQ, S_SQ_W, S_OUT, S_CLR
  } state_e;

  state_e     state;
  logic [7:0] pos;
  logic [7:0] mb;
  logic       eom;
  logic [6:0] total, n;
  logic [7:0] k;
  logic [7:0] rate;

  assign rate = (rate_bytes == 8'd0) ? 8'd1 :
                (rate_bytes > 8'(ksh_pkg::StateBytes)) ? 8'(ksh_pkg::StateBytes) : rate_bytes;
  assign in_ready = (state == S_IDLE);
  assign rd_pos = k;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_ABS: begin
        if (!stat.perm_busy) begin
          if (pos >= rate) cmd.perm_start = 1'b1;
          else begin
            cmd.xor_en = 1'b1; cmd.xor_pos = pos; cmd.xor_val = mb;
          end
        end
      end
      S_ABS_W: cmd.perm_start = (pos >= rate);
      S_EOM: cmd.perm_start = (pos >= rate);
      S_SUF: begin
        cmd.xor_en = 1'b1; cmd.xor_pos = pos; cmd.xor_val = domain_suffix;
        cmd.perm_start = domain_suffix[7] && (pos == rate - 8'd1);
      end
      S_PAD: begin
        cmd.xor_en = 1'b1; cmd.xor_pos = rate - 8'd1; cmd.xor_val = ksh_pkg::PadByte;
        cmd.perm_start = 1'b1;
      end
      S_SQ: cmd.perm_start = (k >= rate);
      S_CLR: cmd.clear = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos <= '0;
      out_valid <= 1'b0;
      k <= '0;
      n <= '0;
      total <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          mb <= message_byte; eom <= end_of_message;
          total <= (output_bytes > 7'(MaxOut)) ? 7'(MaxOut) : output_bytes;
          if (has_byte) state <= S_ABS;
          else if (end_of_message) state <= S_EOM;
        end
        S_ABS: if (!stat.perm_busy) begin
          if (pos >= rate) pos <= '0;
          else begin
            pos <= pos + 8'd1;
            state <= S_ABS_W;
          end
        end
        S_ABS_W: if (!stat.perm_busy && !cmd.perm_start) begin
          state <= eom ? S_EOM : S_IDLE;
        end else if (cmd.perm_start) pos <= '0;
        S_EOM: if (!stat.perm_busy) begin
          if (pos >= rate) pos <= '0;
          else state <= S_SUF;
        end
        S_SUF: state <= S_SUF_W;
        S_SUF_W: if (!stat.perm_busy) state <= S_PAD;
        S_PAD: state <= S_PAD_W;
        S_PAD_W: if (!stat.perm_busy) begin
          k <= '0; n <= '0;
          state <= (total == 7'd0) ? S_CLR : S_SQ;
        end
        S_SQ: if (k >= rate) begin
          k <= '0; state <= S_SQ_W;
        end else begin
          digest_byte <= rd_byte;
          last_byte <= (n + 7'd1 == total);
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_SQ_W: if (!stat.perm_busy) state <= S_SQ;
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          k <= k + 8'd1;
          n <= n + 7'd1;
          state <= (n + 7'd1 == total) ? S_CLR : S_SQ;
        end
        S_CLR: begin
          pos <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= 8'(ksh_pkg::StateBytes)) else $error("position overflow");
  a_out_only: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("output outside S_OUT");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> n < total) else $error("too many results");
endmodule

FILE: design/keccak_sponge_hash.sv
// Keccak sponge: each byte is absorbed through S_ABS and S_ABS_W; each permutation runs
// one round per cycle on a single round unit.
// End of message: suffix, pad and permutation (plus an extra permutation when the
// suffix top bit lands on the last rate byte), then the digest bytes, one permutation per extra block.
// One item is worked at a time; the input waits until its results are all taken.
// Reset (synchronous, active high) zeroes the state and loads the default registers.
module keccak_sponge_hash #(
  parameter int MAX_OUTPUT_BYTES = 64
) (
  input  logic clk,
  input  logic rst,
  ksh_stream_if.sink   in_ch,
  ksh_stream_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  logic [7:0] rate_bytes;
  logic [7:0] domain_suffix;
  logic [6:0] output_bytes;
  ksh_pkg::dp_cmd_t  cmd;
  ksh_pkg::dp_stat_t stat;
  logic [7:0] rd_byte, rd_pos;

  // Configuration registers; writes to unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_bytes <= 8'd136;
      domain_suffix <= 8'h06;
      output_bytes <= 7'd32;
    end else if (cfg_we) begin
      if (cfg_index == ksh_pkg::CFG_RATE) rate_bytes <= cfg_data;
      if (cfg_index == ksh_pkg::CFG_SUFFIX) domain_suffix <= cfg_data;
      if (cfg_index == ksh_pkg::CFG_OUTLEN) output_bytes <= cfg_data[6:0];
    end
  end

  // Input payload is {message_byte, has_byte, end_of_message};
  // output payload is {digest_byte, last_byte}.
  ksh_ctrl #(.MaxOut(MAX_OUTPUT_BYTES)) u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .message_byte(in_ch.data[9:2]), .has_byte(in_ch.data[1]),
    .end_of_message(in_ch.data[0]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .digest_byte(out_ch.data[8:1]), .last_byte(out_ch.data[0]),
    .rate_bytes, .domain_suffix, .output_bytes,
    .cmd, .stat, .rd_byte, .rd_pos
  );

  ksh_datapath u_dp (
    .clk, .rst, .cmd, .stat, .rd_byte, .rd_pos
  );
endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

// Testbench for the Keccak sponge hash.
// Items are sent on the input channel as {message_byte, has_byte, end_of_message};
// results come back as {digest_byte, last_byte}. A software sponge inside this
// module follows every accepted item and queues the digest bytes that the block
// must produce, and a separate process compares each result as it is taken.
module testbench;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 80;

  typedef struct {
    logic [7:0] digest;
    logic       last;
  } digest_item_t;

  logic clk;
  logic rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  ksh_stream_if #(.W(10)) in_ch ();
  ksh_stream_if #(.W(9))  out_ch ();

  keccak_sponge_hash u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Software copy of the sponge and its registers.
  logic [63:0] lanes[25];
  int unsigned absorb_pos;
  logic [7:0] rate_reg;
  logic [7:0] suffix_reg;
  logic [6:0] outlen_reg;

  digest_item_t pending_digest[$];
  int error_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;

  always #5 clk = ~clk;

  function automatic logic [63:0] rotate_lane(logic [63:0] v, int unsigned r);
    r = r % 64;
    return (r == 0) ? v : ((v << r) | (v >> (64 - r)));
  endfunction

  // Keccak-f[1600]: theta, rho and pi along the lane cycle, chi, then iota with
  // the round constant bits taken from the LFSR.
  task automatic keccak_f();
    logic [63:0] col[5];
    logic [63:0] row[5];
    logic [63:0] dval, carry, held;
    logic [7:0] lfsr;
    int px, py, ny;
    lfsr = 8'h01;
    for (int rnd = 0; rnd < 24; rnd++) begin
      for (int x = 0; x < 5; x++)
        col[x] = lanes[x] ^ lanes[x+5] ^ lanes[x+10] ^ lanes[x+15] ^ lanes[x+20];
      for (int x = 0; x < 5; x++) begin
        dval = col[(x+4)%5] ^ rotate_lane(col[(x+1)%5], 1);
        for (int y = 0; y < 5; y++) lanes[x+5*y] ^= dval;
      end
      px = 1; py = 0;
      carry = lanes[1];
      for (int t = 0; t < 24; t++) begin
        ny = (2*px + 3*py) % 5;
        px = py;
        py = ny;
        held = lanes[px+5*py];
        lanes[px+5*py] = rotate_lane(carry, ((t+1)*(t+2)/2) % 64);
        carry = held;
      end
      for (int y = 0; y < 5; y++) begin
        for (int x = 0; x < 5; x++) row[x] = lanes[x+5*y];
        for (int x = 0; x < 5; x++)
          lanes[x+5*y] = row[x] ^ (~row[(x+1)%5] & row[(x+2)%5]);
      end
      for (int j = 0; j < 7; j++) begin
        if (lfsr[0]) lanes[0][(1 << j) - 1] ^= 1'b1;
        lfsr = lfsr[7] ? ((lfsr << 1) ^ ksh_pkg::LfsrPoly) : (lfsr << 1);
      end
    end
  endtask

  task automatic xor_state_byte(int unsigned pos, logic [7:0] b);
    pos = pos % ksh_pkg::StateBytes;
    lanes[pos/8][(pos%8)*8 +: 8] ^= b;
  endtask

  // Absorbs one item into the software sponge; an end of message pads,
  // squeezes the digest into the expected queue and clears the sponge.
  task automatic absorb_item(logic [7:0] mbyte, logic has, logic eom);
    int unsigned rate, total, k;
    digest_item_t d;
    rate = (rate_reg == 0) ? 1 :
           ((rate_reg > ksh_pkg::StateBytes) ? ksh_pkg::StateBytes : rate_reg);
    if (has) begin
      if (absorb_pos >= rate) begin
        keccak_f();
        absorb_pos = 0;
      end
      xor_state_byte(absorb_pos, mbyte);
      absorb_pos++;
      if (absorb_pos >= rate) begin
        keccak_f();
        absorb_pos = 0;
      end
    end
    if (eom) begin
      if (absorb_pos >= rate) begin
        keccak_f();
        absorb_pos = 0;
      end
      xor_state_byte(absorb_pos, suffix_reg);
      // A suffix whose top bit lands on the last rate byte needs its own block.
      if (suffix_reg[7] && absorb_pos == rate - 1) keccak_f();
      xor_state_byte(rate - 1, ksh_pkg::PadByte);
      keccak_f();
      total = (outlen_reg > 64) ? 64 : outlen_reg;
      k = 0;
      for (int unsigned n = 0; n < total; n++) begin
        if (k >= rate) begin
          keccak_f();
          k = 0;
        end
        d.digest = lanes[k/8][(k%8)*8 +: 8];
        d.last = (n + 1 == total);
        pending_digest.push_back(d);
        k++;
      end
      for (int i = 0; i < 25; i++) lanes[i] = '0;
      absorb_pos = 0;
    end
  endtask

  // Sends one item. It is entered just after a rising edge and returns at the
  // rising edge where the item was accepted, leaving valid high.
  task automatic send_item(logic [7:0] mbyte, logic has, logic eom);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {mbyte, has, eom};
    do @(posedge clk); while (!in_ch.ready);
    absorb_item(mbyte, has, eom);
  endtask

  // Lowers valid and waits until the block has delivered everything and had
  // time to finish any permutation that produces no result.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_digest.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(ksh_pkg::cfg_index_t idx, logic [7:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ksh_pkg::CFG_RATE:   rate_reg = val;
      ksh_pkg::CFG_SUFFIX: suffix_reg = val;
      ksh_pkg::CFG_OUTLEN: outlen_reg = val[6:0];
      default: ;
    endcase
  endtask

  // Sends a message of the given length with random bytes. The end marker
  // rides on the last byte or comes as a separate empty item.
  task automatic send_message(int len);
    logic sep;
    sep = (len == 0) || $urandom_range(0, 1);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !sep);
    if (sep) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Directed cases: defaults, field extremes, rate, suffix and length corners.
  task automatic test_directed();
    // Empty message with the reset settings, then a short one.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // Extreme byte values and an item that carries neither flag.
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    // Longest digest, a zero length and an oversized length.
    write_reg(ksh_pkg::CFG_OUTLEN, 8'd64);
    send_item(8'hA5, 1'b1, 1'b1);
    write_reg(ksh_pkg::CFG_OUTLEN, 8'd0);
    send_item(8'h5A, 1'b1, 1'b1);
    write_reg(ksh_pkg::CFG_OUTLEN, 8'd127);
    send_item(8'h3C, 1'b1, 1'b1);
    // A rate of zero acts as one byte, and very large rates as 200.
    write_reg(ksh_pkg::CFG_OUTLEN, 8'd20);
    write_reg(ksh_pkg::CFG_RATE, 8'd0);
    send_item(8'h11, 1'b1, 1'b0);
    send_item(8'h22, 1'b1, 1'b1);
    write_reg(ksh_pkg::CFG_RATE, 8'd255);
    send_item(8'h33, 1'b1, 1'b1);
    write_reg(ksh_pkg::CFG_RATE, 8'd200);
    send_item(8'hC3, 1'b1, 1'b1);
    // Suffix of zero leaves only the final pad bit.
    write_reg(ksh_pkg::CFG_SUFFIX, 8'h00);
    send_item(8'h00, 1'b0, 1'b1);
    // Suffix top bit on the last rate byte forces an extra permutation.
    write_reg(ksh_pkg::CFG_RATE, 8'd4);
    write_reg(ksh_pkg::CFG_SUFFIX, 8'h86);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h02, 1'b1, 1'b0);
    send_item(8'h03, 1'b1, 1'b1);
    // Shrinking the rate below the current absorb position mid-message.
    write_reg(ksh_pkg::CFG_SUFFIX, 8'h1F);
    write_reg(ksh_pkg::CFG_RATE, 8'd136);
    for (int i = 0; i < 6; i++) send_item(8'(8'h40 + i), 1'b1, 1'b0);
    write_reg(ksh_pkg::CFG_RATE, 8'd3);
    send_item(8'h77, 1'b1, 1'b1);
    settle();
  endtask

  // Random phase: mostly well formed messages with random content, plus some
  // items that carry neither flag. Rate, suffix and length change before some messages.
  task automatic test_random(int items, int sp, int rp);
    int sent, len;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: write_reg(ksh_pkg::CFG_RATE, 8'($urandom_range(1, 8)));
          1: write_reg(ksh_pkg::CFG_RATE, 8'($urandom_range(0, 255)));
          default: write_reg(ksh_pkg::CFG_RATE, $urandom_range(0, 1) ? 8'd136 : 8'd72);
        endcase
        write_reg(ksh_pkg::CFG_SUFFIX, 8'($urandom_range(0, 255)));
        write_reg(ksh_pkg::CFG_OUTLEN, $urandom_range(0, 9) == 0 ?
                  8'($urandom_range(0, 127)) : 8'($urandom_range(1, 40)));
      end
      if ($urandom_range(0, 7) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        sent++;
      end
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
      // Keep the phase close to its item budget.
      if (len > items - sent - 1) len = (items - sent > 0) ? items - sent - 1 : 0;
      send_message(len);
      sent += len + 1;
    end
    settle();
  endtask

  // Receiver stalls, driven at the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result checker: each accepted digest byte against the oldest expectation.
  always @(posedge clk) begin
    digest_item_t exp_item;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_digest.size() == 0) begin
        $error("unexpected result: digest_byte %0h last_byte %0b",
               out_ch.data[8:1], out_ch.data[0]);
        error_count++;
      end else begin
        exp_item = pending_digest.pop_front();
        if (out_ch.data[8:1] !== exp_item.digest) begin
          $error("digest_byte expected %0h actual %0h", exp_item.digest, out_ch.data[8:1]);
          error_count++;
        end
        if (out_ch.data[0] !== exp_item.last) begin
          $error("last_byte expected %0b actual %0b", exp_item.last, out_ch.data[0]);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = ksh_pkg::CFG_RATE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 30;
    recv_idle_pct = 51;
    for (int i = 0; i < 25; i++) lanes[i] = '0;
    absorb_pos = 0;
    rate_reg = 8'd136;
    suffix_reg = 8'h06;
    outlen_reg = 7'd32;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(120, 30, 51);
    test_random(120, 51, 30);
    test_random(110, 0, 0);

    if (error_count == 0 && pending_digest.size() == 0) begin
      $display("testbench OK");
    end else begin
      if (pending_digest.size() != 0)
        $error("%0d digest bytes never arrived", pending_digest.size());
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

FILE: files.f
design/ksh_pkg.sv
design/ksh_stream_if.sv
design/ksh_datapath.sv
design/ksh_ctrl.sv
design/keccak_sponge_hash.sv
test/testbench.sv
